// ===== rtl/core/fat12_cluster_chain_walker_assert.svh =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_assert.svh
// Assertion macros used by the chain walker checker.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAT12CCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fat12ccw: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FAT12CCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fat12ccw: check failed");

`endif

// ===== rtl/core/fat12ccw_pkg.sv =====
// ----------------------------------------------------------------------------
// fat12ccw_pkg
// Shared types, codes and field layout of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fat12ccw_pkg;

    localparam int TABLE_BYTES_DEF = 8192;   // default table size in bytes
    localparam int SEGMENT_MAX     = 64;     // most clusters per walk

    localparam int ADDR_W    = 13;
    localparam int BYTE_W    = 8;
    localparam int CLUSTER_W = 12;
    localparam int LIMIT_W   = 7;
    localparam int STATUS_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SEGMENT_MAX);

    localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] BAD_MARK   = 12'hFF7;
    localparam logic [CLUSTER_W-1:0] ENTRY_FREE = 12'h000;
    localparam logic [CLUSTER_W-1:0] ENTRY_RSVD = 12'h001;

    // input tdata: table_byte_addr, table_byte, start_cluster, zero pad
    localparam int S_ADDR_LSB  = 0;
    localparam int S_BYTE_LSB  = S_ADDR_LSB + ADDR_W;
    localparam int S_START_LSB = S_BYTE_LSB + BYTE_W;
    localparam int S_TDATA_W   = 40;

    // output tdata: cluster, next_cluster
    localparam int M_CLUSTER_LSB = 0;
    localparam int M_NEXT_LSB    = M_CLUSTER_LSB + CLUSTER_W;
    localparam int M_TDATA_W     = 24;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_WALK = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_LIMIT = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

endpackage

// ===== rtl/core/fat12_cluster_chain_walker.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker - follows a FAT12 cluster chain in a local table
// Load item: writes one table byte, no result. Walk item: taken while idle,
// then a bank read and an evaluate step per cluster, up to 64 clusters per
// walk; each read depends on the entry read before it. Evaluate waits while
// the result register is stalled. Reset (aresetn low, synchronous) clears the
// control state and sets segment_limit to 64; the table stays undefined.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker
    import fat12ccw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [12:0] table_byte_addr, [20:13] table_byte,
                                            // [32:21] start_cluster, [39:33] zero
    input  logic                 s_tuser,   // [0] req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] cluster, [23:12] next_cluster
    output logic                 m_tlast,   // last
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data   // segment_limit
);

    // Table is split into an even-byte bank and an odd-byte bank, so both
    // bytes of one 16-bit entry word come out of a single read.
    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int CMP_W      = ADDR_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [LIMIT_W-1:0]     limit_cfg_reg;
    logic [CLUSTER_W-1:0]   cur_reg, cur_next;      // cluster being looked up
    logic [LIMIT_W-1:0]     cnt_reg, cnt_next;      // results of this walk so far
    logic [LIMIT_W-1:0]     lim_reg, lim_next;      // clamped limit, latched per walk
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [BYTE_W-1:0]      even_mem [BANK_DEPTH];
    logic [BYTE_W-1:0]      odd_mem  [BANK_DEPTH];
    logic [BYTE_W-1:0]      even_q_reg, odd_q_reg;
    logic                   idx_odd_reg, oob_lo_reg, oob_hi_reg;

    logic [CLUSTER_W-1:0]   out_cluster_reg, out_next_reg;
    logic                   out_last_reg;
    status_t                out_status_reg;

    // input unpack
    logic                   in_accept;
    logic [ADDR_W-1:0]      ld_addr;
    logic [BYTE_W-1:0]      ld_byte;
    logic [CLUSTER_W-1:0]   start_cluster;
    logic                   ld_we;
    logic                   walk_start;
    logic [LIMIT_W-1:0]     lim_clamped;

    // walk datapath
    logic [ADDR_W-1:0]      idx_lo, idx_hi;
    logic                   rd_en;
    logic [BYTE_W-1:0]      lo_byte, hi_byte;
    logic [2*BYTE_W-1:0]    word;
    logic [CLUSTER_W-1:0]   entry;
    logic [LIMIT_W-1:0]     cnt_inc;
    logic                   is_end, is_bad, at_limit, stop;
    status_t                status;
    logic                   out_free, out_load;

    assign in_accept     = s_tvalid && s_tready;
    assign ld_addr       = s_tdata[S_ADDR_LSB +: ADDR_W];
    assign ld_byte       = s_tdata[S_BYTE_LSB +: BYTE_W];
    assign start_cluster = s_tdata[S_START_LSB +: CLUSTER_W];

    // Loads past the end of the table are dropped.
    assign ld_we = in_accept && (s_tuser == REQ_LOAD)
                   && ({1'b0, ld_addr} < CMP_W'(TABLE_BYTES));
    assign walk_start = in_accept && (s_tuser == REQ_WALK);

    // A limit of 0 behaves as 1, anything past SEGMENT_MAX as SEGMENT_MAX.
    always_comb begin
        priority if (limit_cfg_reg == '0) begin
            lim_clamped = LIMIT_W'(1);
        end else if (limit_cfg_reg > LIMIT_W'(SEGMENT_MAX)) begin
            lim_clamped = LIMIT_W'(SEGMENT_MAX);
        end else begin
            lim_clamped = limit_cfg_reg;
        end
    end

    // Byte index of the entry: c * 3 / 2 = c + (c >> 1). Max 6142, fits 13 bits.
    assign idx_lo = {1'b0, cur_reg} + {2'b0, cur_reg[CLUSTER_W-1:1]};
    assign idx_hi = idx_lo + ADDR_W'(1);
    assign rd_en  = (state_reg == ST_READ);

    // Odd bank always holds byte (idx_lo >> 1) * 2 + 1, even bank byte
    // ((idx_lo + 1) >> 1) * 2; which one is the low byte follows idx_lo[0].
    always_ff @(posedge aclk) begin
        if (ld_we && !ld_addr[0]) begin
            even_mem[ld_addr[BANK_AW:1]] <= ld_byte;
        end
        if (rd_en) begin
            even_q_reg <= even_mem[idx_hi[BANK_AW:1]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_we && ld_addr[0]) begin
            odd_mem[ld_addr[BANK_AW:1]] <= ld_byte;
        end
        if (rd_en) begin
            odd_q_reg <= odd_mem[idx_lo[BANK_AW:1]];
        end
    end

    // Byte routing and out-of-table flags travel with the read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            idx_odd_reg <= idx_lo[0];
            oob_lo_reg  <= ({1'b0, idx_lo} >= CMP_W'(TABLE_BYTES));
            oob_hi_reg  <= ({1'b0, idx_hi} >= CMP_W'(TABLE_BYTES));
        end
    end

    // Entry decode: bytes past the table read as zero.
    assign lo_byte = oob_lo_reg ? '0 : (idx_odd_reg ? odd_q_reg : even_q_reg);
    assign hi_byte = oob_hi_reg ? '0 : (idx_odd_reg ? even_q_reg : odd_q_reg);
    assign word    = {hi_byte, lo_byte};
    assign entry   = cur_reg[0] ? word[2*BYTE_W-1:4] : word[CLUSTER_W-1:0];

    assign cnt_inc  = cnt_reg + LIMIT_W'(1);
    assign is_end   = (entry >= END_MARK);
    assign is_bad   = (entry == ENTRY_FREE) || (entry == ENTRY_RSVD) || (entry == BAD_MARK);
    assign at_limit = (cnt_inc >= lim_reg);
    assign stop     = is_end || is_bad || at_limit;

    // end of chain beats a bad entry, which beats the segment limit
    always_comb begin
        priority if (is_end) begin
            status = STATUS_OK;
        end else if (is_bad) begin
            status = STATUS_ERROR;
        end else if (at_limit) begin
            status = STATUS_LIMIT;
        end else begin
            status = STATUS_OK;
        end
    end

    // Result register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        lim_next      = lim_reg;
        out_load      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (walk_start) begin
                    cur_next   = start_cluster;
                    cnt_next   = '0;
                    lim_next   = lim_clamped;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // bank outputs hold here (no read enable), so a stall is safe
                if (out_free) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    cur_next      = entry;
                    cnt_next      = cnt_inc;
                    state_next    = stop ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            limit_cfg_reg <= LIMIT_RESET;
            cur_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cur_reg      <= cur_next;
            cnt_reg      <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                limit_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg <= lim_next;
        if (out_load) begin
            out_cluster_reg <= cur_reg;
            out_next_reg    <= entry;
            out_last_reg    <= stop;
            out_status_reg  <= status;
        end
    end

    // one item at a time: input is taken only between walks
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_next_reg, out_cluster_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/core/fat12ccw_checker.sv =====
// ----------------------------------------------------------------------------
// fat12ccw_checker
// Port-level checks on the chain walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_assert.svh"

module fat12ccw_checker
    import fat12ccw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [STATUS_W-1:0]  m_tuser
);

    logic [CLUSTER_W-1:0]                   nx_field;
    logic                                   walk_acc;
    logic                                   out_stall;
    logic [M_TDATA_W+STATUS_W:0]            out_word;
    logic                                   nx_err;
    logic                                   nx_end;

    assign nx_field  = m_tdata[M_NEXT_LSB +: CLUSTER_W];
    assign walk_acc  = s_tvalid && s_tready && (s_tuser == REQ_WALK);
    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = {m_tdata, m_tlast, m_tuser};
    assign nx_err    = (nx_field == ENTRY_FREE) || (nx_field == ENTRY_RSVD)
                       || (nx_field == BAD_MARK);
    assign nx_end    = (nx_field >= END_MARK);

    // held result stays put
    `FAT12CCW_ASSERT_NXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(out_word))

    // a stop status only closes a walk
    `FAT12CCW_ASSERT_IMP(a_status_last, aclk, aresetn, m_tvalid && (m_tuser != STATUS_OK), m_tlast)

    // error status only for free, reserved or bad entries
    `FAT12CCW_ASSERT_IMP(a_err_entry, aclk, aresetn, m_tvalid && (m_tuser == STATUS_ERROR), nx_err)

    // a clean last result carries an end-of-chain mark
    `FAT12CCW_ASSERT_IMP(a_end_mark, aclk, aresetn, m_tvalid && m_tlast && (m_tuser == STATUS_OK), nx_end)

    // input is closed right after a walk is taken
    `FAT12CCW_ASSERT_NXT(a_walk_busy, aclk, aresetn, walk_acc, !s_tready)

endmodule

bind fat12_cluster_chain_walker fat12ccw_checker u_fat12ccw_checker (.*);

// ===== test/fat12_chain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_chain_checker
// Watches the load, walk, config and result channels of the chain walker,
// follows every walked chain in its own copy of the table, and compares each
// result item in order against the predicted chain link.
// ----------------------------------------------------------------------------
module fat12_chain_checker
    import fat12ccw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic [STATUS_W-1:0]  m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output int                   error_count,
    output int                   outstanding
);

    typedef struct {
        logic [CLUSTER_W-1:0] cluster;
        logic [CLUSTER_W-1:0] next_cl;
        logic                 last;
        status_t              status;
    } chain_link_t;

    logic [BYTE_W-1:0]  fat_copy [TABLE_BYTES_DEF];
    logic [LIMIT_W-1:0] seg_limit;
    chain_link_t        pending_links [$];
    chain_link_t        want;
    int                 shown;

    initial begin
        error_count = 0;
        outstanding = 0;
        shown       = 0;
        seg_limit   = LIMIT_RESET;
    end

    function automatic logic [BYTE_W-1:0] fat_byte(int idx);
        if (idx >= TABLE_BYTES_DEF) return '0;
        return fat_copy[idx];
    endfunction

    // 12-bit entry: little-endian word at c*3/2, low or high 12 bits by parity
    function automatic logic [CLUSTER_W-1:0] fat_entry(logic [CLUSTER_W-1:0] c);
        int          idx;
        logic [15:0] word;
        idx  = (int'(c) * 3) >> 1;
        word = {fat_byte(idx + 1), fat_byte(idx)};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    task automatic follow_chain(logic [CLUSTER_W-1:0] start);
        int                   cap;
        int                   count;
        logic [CLUSTER_W-1:0] c;
        logic [CLUSTER_W-1:0] nx;
        chain_link_t          lk;
        logic                 done;
        if (seg_limit == 0) cap = 1;
        else if (seg_limit > SEGMENT_MAX) cap = SEGMENT_MAX;
        else cap = seg_limit;
        c     = start;
        count = 0;
        done  = 1'b0;
        while (!done) begin
            nx = fat_entry(c);
            count++;
            lk.cluster = c;
            lk.next_cl = nx;
            lk.status  = STATUS_OK;
            // end of chain beats an error entry, which beats the segment limit
            if (nx >= END_MARK) begin
                done = 1'b1;
            end else if (nx == ENTRY_FREE || nx == ENTRY_RSVD || nx == BAD_MARK) begin
                lk.status = STATUS_ERROR;
                done      = 1'b1;
            end else if (count >= cap) begin
                lk.status = STATUS_LIMIT;
                done      = 1'b1;
            end
            lk.last = done;
            pending_links.push_back(lk);
            c = nx;
        end
    endtask

    task automatic flag_error(string msg);
        error_count++;
        if (shown < 10) $display("%0t ns: %s", $time, msg);
        shown++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seg_limit = LIMIT_RESET;
            pending_links.delete();
        end else begin
            if (cfg_valid && cfg_ready) seg_limit = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_LOAD) begin
                    if (s_tdata[S_ADDR_LSB +: ADDR_W] < TABLE_BYTES_DEF)
                        fat_copy[s_tdata[S_ADDR_LSB +: ADDR_W]] = s_tdata[S_BYTE_LSB +: BYTE_W];
                end else begin
                    follow_chain(s_tdata[S_START_LSB +: CLUSTER_W]);
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_links.size() == 0) begin
                    flag_error($sformatf("unexpected item: cluster=%h next=%h last=%b status=%0d",
                        m_tdata[M_CLUSTER_LSB +: CLUSTER_W], m_tdata[M_NEXT_LSB +: CLUSTER_W],
                        m_tlast, m_tuser));
                end else begin
                    want = pending_links.pop_front();
                    if (m_tdata[M_CLUSTER_LSB +: CLUSTER_W] !== want.cluster ||
                        m_tdata[M_NEXT_LSB +: CLUSTER_W] !== want.next_cl ||
                        m_tlast !== want.last || m_tuser !== want.status) begin
                        flag_error($sformatf(
                            "mismatch: exp cluster=%h next=%h last=%b status=%0d, got %h %h %b %0d",
                            want.cluster, want.next_cl, want.last, want.status,
                            m_tdata[M_CLUSTER_LSB +: CLUSTER_W], m_tdata[M_NEXT_LSB +: CLUSTER_W],
                            m_tlast, m_tuser));
                    end
                end
            end
        end
        outstanding = pending_links.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives table loads, chain walks and segment limit writes into the FAT12
// cluster chain walker with random idling on both streams until the last phase;
// the checker beside the block predicts every chain link and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import fat12ccw_pkg::*;

    localparam int PHASE_ITEMS = 12;   // input items per random phase
    localparam int DRAIN_GAP   = 8;    // cycles after the last result before a cfg write

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b1;
    logic                 cfg_valid = 1'b0;
    logic [LIMIT_W-1:0]   cfg_data  = '0;

    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_ready;

    int error_count;
    int outstanding;

    // Stimulus-side image of the table. It is only used to steer walks so
    // that they never touch a byte that was never loaded.
    bit   [7:0]           shadow  [TABLE_BYTES_DEF];
    bit                   written [TABLE_BYTES_DEF];
    logic [CLUSTER_W-1:0] walk_starts [$];
    int                   cur_cap = SEGMENT_MAX;
    bit                   idle_on = 1'b0;
    int                   items_sent = 0;
    int                   stall_left = 0;
    int                   calm_left = 0;

    always #4 aclk = ~aclk;

    fat12_cluster_chain_walker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fat12_chain_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Hard stop well past the slowest legal run.
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result-side backpressure: random stall bursts, calm stretches in between,
    // and none at all once idling is switched off.
    always @(negedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (calm_left > 0) begin
            m_tready <= 1'b1;
            calm_left--;
        end else begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    m_tready   <= 1'b0;
                    stall_left = $urandom_range(0, 5);
                end
                2: begin
                    m_tready  <= 1'b1;
                    calm_left = $urandom_range(20, 60);
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // a limit of 0 behaves as 1, anything above the maximum as the maximum
    function automatic int limit_cap(logic [LIMIT_W-1:0] v);
        if (v == 0) return 1;
        if (v > SEGMENT_MAX) return SEGMENT_MAX;
        return v;
    endfunction

    function automatic logic [CLUSTER_W-1:0] shadow_entry(logic [CLUSTER_W-1:0] c);
        int          idx;
        logic [15:0] word;
        idx  = (int'(c) * 3) >> 1;
        word = {shadow[idx + 1], shadow[idx]};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    // True when a walk from start only reads loaded bytes under the current limit.
    function automatic bit chain_safe(logic [CLUSTER_W-1:0] start);
        logic [CLUSTER_W-1:0] c;
        logic [CLUSTER_W-1:0] nx;
        int                   idx;
        c = start;
        for (int n = 1; n <= cur_cap; n++) begin
            idx = (int'(c) * 3) >> 1;
            if (!written[idx] || !written[idx + 1]) return 1'b0;
            nx = shadow_entry(c);
            if (nx >= END_MARK || nx == ENTRY_FREE || nx == ENTRY_RSVD || nx == BAD_MARK)
                return 1'b1;
            c = nx;
        end
        return 1'b1;
    endfunction

    // One input item. Entered right after a handshake edge (or idle); inputs
    // only change on the falling edge, valid stays high between back-to-back items.
    task automatic send_item(req_t kind, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                             logic [CLUSTER_W-1:0] start);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        else gap = 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, start, data, addr};
        s_tuser  <= kind;
        if (kind == REQ_LOAD) begin
            shadow[addr]  = data;
            written[addr] = 1'b1;
        end
        items_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // unused fields of each item, but for the zero pad, carry random values
    task automatic load_byte(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
        send_item(REQ_LOAD, addr, data, CLUSTER_W'($urandom_range(0, 4095)));
    endtask

    task automatic walk_from(logic [CLUSTER_W-1:0] start);
        if (chain_safe(start))
            send_item(REQ_WALK, ADDR_W'($urandom_range(0, 8191)),
                      BYTE_W'($urandom_range(0, 255)), start);
    endtask

    // Two byte loads per entry; the neighbor's nibble in the shared byte is kept.
    task automatic set_entry(logic [CLUSTER_W-1:0] c, logic [CLUSTER_W-1:0] val);
        int          idx;
        logic [15:0] word;
        idx  = (int'(c) * 3) >> 1;
        word = {shadow[idx + 1], shadow[idx]};
        if (c[0]) word[15:4] = val;
        else word[11:0] = val;
        load_byte(ADDR_W'(idx), word[7:0]);
        load_byte(ADDR_W'(idx + 1), word[15:8]);
    endtask

    // Let every predicted result drain, then wait DRAIN_GAP more for a trailing load.
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_cap = limit_cap(v);
    endtask

    // Distinct random clusters linked in order, closed by an end mark, an error
    // entry or a jump back into the chain; now and then one link is left stale.
    task automatic build_chain;
        int                   len;
        int                   skip;
        logic [CLUSTER_W-1:0] members [$];
        logic [CLUSTER_W-1:0] c;
        logic [CLUSTER_W-1:0] term;
        bit                   dup;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 30);
        else len = $urandom_range(1, 6);
        while (members.size() < len) begin
            c   = $urandom_range(0, 4095);
            dup = 1'b0;
            foreach (members[i]) if (members[i] == c) dup = 1'b1;
            if (!dup) members.push_back(c);
        end
        if (len > 2 && $urandom_range(0, 7) == 0) skip = $urandom_range(1, len - 2);
        else skip = -1;
        for (int i = 0; i < len - 1; i++)
            if (i != skip) set_entry(members[i], members[i + 1]);
        case ($urandom_range(0, 2))
            0: term = $urandom_range(12'hFF8, 12'hFFF);
            1: begin
                case ($urandom_range(0, 2))
                    0:       term = ENTRY_FREE;
                    1:       term = ENTRY_RSVD;
                    default: term = BAD_MARK;
                endcase
            end
            default: term = members[$urandom_range(0, len - 1)];
        endcase
        set_entry(members[len - 1], term);
        walk_from(members[0]);
        walk_starts.push_back(members[0]);
    endtask

    // Mostly fresh chains; the rest is stray loads and re-walks of old chains,
    // which stray loads may have bent.
    task automatic random_phase(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: build_chain();
                6, 7: begin
                    repeat ($urandom_range(1, 3))
                        load_byte(ADDR_W'($urandom_range(0, 8191)), BYTE_W'($urandom_range(0, 255)));
                end
                default: begin
                    if (walk_starts.size() > 0)
                        walk_from(walk_starts[$urandom_range(0, walk_starts.size() - 1)]);
                    else
                        walk_from(CLUSTER_W'($urandom_range(0, 4095)));
                end
            endcase
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] plan [5];

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // Directed part at the reset limit of 64.
        set_entry(0, 12'hFFF);               // reserved start 0, highest end mark
        walk_from(0);
        set_entry(1, ENTRY_FREE);            // reserved start 1, free entry
        walk_from(1);
        set_entry(12'hFFF, BAD_MARK);        // top cluster, bad entry
        walk_from(12'hFFF);
        set_entry(2, 3);                     // two-cluster loop, ends at the limit
        set_entry(3, 2);
        walk_from(2);
        set_entry(5, 12'hFF6);               // largest continuing entry, then reserved
        set_entry(12'hFF6, ENTRY_RSVD);
        walk_from(5);
        set_entry(6, END_MARK);              // lowest end mark
        walk_from(6);

        // Limit 1: every walk stops on its first link, so precedence shows.
        set_limit(1);
        walk_from(6);                        // end of chain over limit
        walk_from(12'hFFF);                  // error over limit
        walk_from(2);                        // plain limit stop

        // Random phases over several limits, out-of-range ones included.
        plan[0] = 0;
        plan[1] = 127;
        plan[2] = $urandom_range(2, 63);
        plan[3] = 65;
        plan[4] = SEGMENT_MAX;
        for (int p = 0; p < 5; p++) begin
            set_limit(plan[p]);
            if (p == 4) idle_on = 1'b0;      // last stretch runs at full rate
            random_phase(PHASE_ITEMS);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (16) @(posedge aclk);

        if (error_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
